// ===== sv/wshs_pkg.sv =====
// shared types and constants of the weighted server health selector
package wshs_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_ISSUE,
        S_UPD_WAIT,
        S_UPD_AVG,
        S_UPD_RATE,
        S_UPD_DIV,
        S_UPD_WB,
        S_SCAN_ISSUE,
        S_SCAN_WAIT,
        S_SCAN_DIV,
        S_SCAN_MUL,
        S_SCAN_SUM,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CFG_ACTIVE  = 3'd0,
        CFG_PROTO   = 3'd1,
        CFG_SECURE  = 3'd2,
        CFG_BASE    = 3'd3,
        CFG_MINQ    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PROTO_UDP   = 3'd0,
        PROTO_TCP   = 3'd1,
        PROTO_HTTPS = 3'd2,
        PROTO_TLS   = 3'd3,
        PROTO_QUIC  = 3'd4
    } t_proto;

    typedef struct packed {
        logic [31:0] tot;
        logic [31:0] okc;
        logic [31:0] avg;
        logic [16:0] rate;
        logic        usable;
    } t_rec;

    localparam int unsigned REC_W = $bits(t_rec);
    localparam t_rec REC_RESET = '{tot: 32'd0, okc: 32'd0, avg: 32'd0,
                                   rate: 17'd0, usable: 1'b1};

    localparam logic [15:0] W_RATE       = 16'd45875;
    localparam logic [14:0] W_SPEED      = 15'd19661;
    localparam logic [16:0] BONUS_QUIC   = 17'd9830;
    localparam logic [16:0] BONUS_HTTPS  = 17'd6554;
    localparam logic [16:0] BONUS_TLS    = 17'd5243;
    localparam logic [16:0] BONUS_SECURE = 17'd3277;
    localparam logic [16:0] ONE_Q16      = 17'd65536;
    localparam logic [16:0] HALF_Q16     = 17'd32768;
    localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;
    localparam logic [4:0]  RESET_ACTIVE = 5'd0;
    localparam logic [15:0] RESET_BASE   = 16'd5000;
    localparam logic [7:0]  RESET_MINQ   = 8'd10;

endpackage

// ===== sv/wshs_if.sv =====
// channel interfaces: request, result and configuration write
interface wshs_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  entry_index;
    logic        succeeded;
    logic [31:0] response_ms;
    modport source(output valid, mode, entry_index, succeeded, response_ms, input ready);
    modport sink(input valid, mode, entry_index, succeeded, response_ms, output ready);
endinterface

interface wshs_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  chosen_index;
    logic        none_available;
    logic [16:0] top_score;
    logic [16:0] rate_after;
    logic        still_available;
    modport source(output valid, chosen_index, none_available, top_score, rate_after,
                   still_available, input ready);
    modport sink(input valid, chosen_index, none_available, top_score, rate_after,
                 still_available, output ready);
endinterface

interface wshs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/wshs_ram.sv =====
// generic single write port ram with registered read
module wshs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/wshs_div.sv =====
// radix-2 fraction divider: floor(num * 2^16 / den) for num < den
module wshs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [15:0] r_quot, n_quot;
    logic [32:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        trial  = {r_rem, 1'b0};
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem  = 32'(trial - {1'b0, r_den});
                n_quot = {r_quot[14:0], 1'b1};
            end else begin
                n_rem  = trial[31:0];
                n_quot = {r_quot[14:0], 1'b0};
            end
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== sv/weighted_server_health_selector.sv =====
// Health records for up to ENTRIES servers live in one RAM with a registered read. One item
// is in work at a time. An update reads the record, divides the new average by five when
// the query succeeded and the stored average is nonzero, computes the success rate in the
// shared divider unless every query succeeded, and writes the record back. A select walks
// the first active_count entries one after another: it skips a disabled entry, needs no
// divider for an entry whose average is zero or at most the baseline, and runs the divider
// for the speed factor of any other entry.
// A result waits in the output register while the next transaction is accepted.
module weighted_server_health_selector #(
    parameter int ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wshs_in_if.sink    i_in,
    wshs_out_if.source o_out,
    wshs_cfg_if.sink   i_cfg
);
    import wshs_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    t_state r_state, n_state;

    logic [4:0]  r_active;
    logic [47:0] r_proto;
    logic [15:0] r_secure;
    logic [15:0] r_base;
    logic [7:0]  r_minq;

    logic [ENTRIES-1:0] r_vld;
    logic               r_rd_vld;

    logic        r_mode, n_mode;
    logic [3:0]  r_idx, n_idx;
    logic        r_ok, n_ok;
    logic [31:0] r_time, n_time;
    t_rec        r_rec, n_rec;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [16:0] r_speed, n_speed;
    logic [32:0] r_p1, n_p1;
    logic [32:0] r_p2, n_p2;
    logic        r_found, n_found;
    logic [16:0] r_best, n_best;
    logic [3:0]  r_best_i, n_best_i;
    logic [34:0] r_x, n_x;
    logic [2:0]  r_rem5, n_rem5;
    logic [2:0]  r_step, n_step;
    logic [16:0] r_res_rate, n_res_rate;
    logic        r_res_use, n_res_use;

    logic        r_ov;
    logic [3:0]  r_o_chosen;
    logic        r_o_none;
    logic [16:0] r_o_best;
    logic [16:0] r_o_rate;
    logic        r_o_use;

    logic          in_acc;
    logic          idx_ok;
    logic [6:0]    idx_ext;
    logic [6:0]    cnt_ext;
    logic [31:0]   scan_n;
    logic          scan_end;
    t_rec          rec_rd;
    logic [REC_W-1:0] ram_q;
    logic          ram_we;
    logic [IW-1:0] ram_raddr;
    logic [IW-1:0] ram_waddr;
    t_rec          wb_rec;
    logic          new_use;
    logic          div_start;
    logic [31:0]   div_num;
    logic [31:0]   div_den;
    logic          div_done;
    logic [15:0]   div_q;
    logic [34:0]   xv;
    logic [3:0]    rv;
    logic [33:0]   psum;
    logic [16:0]   score;
    logic [16:0]   bonus;
    logic [7:0]    sh_amt;
    logic [47:0]   proto_sh;
    logic          speed_one;

    assign in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign idx_ok    = (32'(i_in.entry_index) < ENTRIES);
    assign idx_ext   = 7'(r_idx);
    assign cnt_ext   = 7'(r_cnt);
    assign scan_n    = (32'(r_active) < ENTRIES) ? 32'(r_active) : 32'(ENTRIES);
    assign scan_end  = (32'(r_cnt) >= scan_n);
    assign rec_rd    = r_rd_vld ? t_rec'(ram_q) : REC_RESET;
    assign ram_raddr = (r_state == S_SCAN_ISSUE) ? cnt_ext[IW-1:0] : idx_ext[IW-1:0];
    assign ram_waddr = idx_ext[IW-1:0];
    assign ram_we    = (r_state == S_UPD_WB);
    assign speed_one = (rec_rd.avg == 32'd0) || ({16'd0, r_base} >= rec_rd.avg);
    assign new_use   = r_rec.usable && !((32'(r_minq) <= r_rec.tot) && (r_rec.rate < HALF_Q16));

    always_comb begin
        wb_rec = r_rec;
        wb_rec.usable = new_use;
    end

    wshs_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(wb_rec),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    wshs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quot (div_q)
    );

    always_comb begin
        div_start = 1'b0;
        div_num   = r_rec.okc;
        div_den   = r_rec.tot;
        case (r_state)
            S_UPD_RATE: begin
                div_start = (r_rec.okc != r_rec.tot);
            end
            S_SCAN_WAIT: begin
                div_start = rec_rd.usable && !speed_one;
                div_num   = {16'd0, r_base};
                div_den   = rec_rd.avg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_in.mode) begin
                        n_state = S_SCAN_ISSUE;
                    end else if (idx_ok) begin
                        n_state = S_UPD_ISSUE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_UPD_ISSUE: n_state = S_UPD_WAIT;
            S_UPD_WAIT: begin
                n_state = (r_ok && rec_rd.avg != 32'd0) ? S_UPD_AVG : S_UPD_RATE;
            end
            S_UPD_AVG: begin
                if (r_step == 3'd6) begin
                    n_state = S_UPD_RATE;
                end
            end
            S_UPD_RATE: begin
                n_state = (r_rec.okc == r_rec.tot) ? S_UPD_WB : S_UPD_DIV;
            end
            S_UPD_DIV: begin
                if (div_done) begin
                    n_state = S_UPD_WB;
                end
            end
            S_UPD_WB: n_state = S_DONE;
            S_SCAN_ISSUE: begin
                n_state = scan_end ? S_DONE : S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                if (!rec_rd.usable) begin
                    n_state = S_SCAN_ISSUE;
                end else if (speed_one) begin
                    n_state = S_SCAN_MUL;
                end else begin
                    n_state = S_SCAN_DIV;
                end
            end
            S_SCAN_DIV: begin
                if (div_done) begin
                    n_state = S_SCAN_MUL;
                end
            end
            S_SCAN_MUL: n_state = S_SCAN_SUM;
            S_SCAN_SUM: n_state = S_SCAN_ISSUE;
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        sh_amt   = 8'(cnt_ext) * 8'd3;
        proto_sh = r_proto >> sh_amt;
        bonus    = '0;
        if (cnt_ext < 7'd16) begin
            case (t_proto'(proto_sh[2:0]))
                PROTO_QUIC:  bonus = BONUS_QUIC;
                PROTO_HTTPS: bonus = BONUS_HTTPS;
                PROTO_TLS:   bonus = BONUS_TLS;
                default:     bonus = '0;
            endcase
            if (r_secure[cnt_ext[3:0]]) begin
                bonus = bonus + BONUS_SECURE;
            end
        end
        psum  = 34'(r_p1) + 34'(r_p2);
        score = psum[32:16] + bonus;
    end

    always_comb begin
        xv = r_x;
        rv = {1'b0, r_rem5};
        for (int k = 0; k < 5; k++) begin
            rv = {rv[2:0], xv[34]};
            if (rv >= 4'd5) begin
                xv = {xv[33:0], 1'b1};
                rv = rv - 4'd5;
            end else begin
                xv = {xv[33:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_idx      = r_idx;
        n_ok       = r_ok;
        n_time     = r_time;
        n_rec      = r_rec;
        n_cnt      = r_cnt;
        n_speed    = r_speed;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_found    = r_found;
        n_best     = r_best;
        n_best_i   = r_best_i;
        n_x        = r_x;
        n_rem5     = r_rem5;
        n_step     = r_step;
        n_res_rate = r_res_rate;
        n_res_use  = r_res_use;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode     = i_in.mode;
                    n_idx      = i_in.entry_index;
                    n_ok       = i_in.succeeded;
                    n_time     = i_in.response_ms;
                    n_cnt      = '0;
                    n_found    = 1'b0;
                    n_best     = '0;
                    n_best_i   = '0;
                    n_res_rate = '0;
                    n_res_use  = 1'b0;
                end
            end
            S_UPD_WAIT: begin
                n_rec = rec_rd;
                if (rec_rd.tot != MAX32) begin
                    n_rec.tot = rec_rd.tot + 32'd1;
                end
                if (r_ok) begin
                    if (rec_rd.okc != MAX32) begin
                        n_rec.okc = rec_rd.okc + 32'd1;
                    end
                    if (rec_rd.avg == 32'd0) begin
                        n_rec.avg = r_time;
                    end
                end
                n_x    = {1'b0, rec_rd.avg, 2'b00} + {3'b000, r_time};
                n_rem5 = '0;
                n_step = '0;
            end
            S_UPD_AVG: begin
                n_x    = xv;
                n_rem5 = rv[2:0];
                n_step = r_step + 3'd1;
                if (r_step == 3'd6) begin
                    n_rec.avg = xv[31:0];
                end
            end
            S_UPD_RATE: begin
                if (r_rec.okc == r_rec.tot) begin
                    n_rec.rate = ONE_Q16;
                end
            end
            S_UPD_DIV: begin
                if (div_done) begin
                    n_rec.rate = {1'b0, div_q};
                end
            end
            S_UPD_WB: begin
                n_res_rate = r_rec.rate;
                n_res_use  = new_use;
            end
            S_SCAN_WAIT: begin
                n_rec   = rec_rd;
                n_speed = ONE_Q16;
                if (!rec_rd.usable) begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_SCAN_DIV: begin
                if (div_done) begin
                    n_speed = {1'b0, div_q};
                end
            end
            S_SCAN_MUL: begin
                n_p1 = 33'(r_rec.rate * W_RATE);
                n_p2 = 33'(r_speed * W_SPEED);
            end
            S_SCAN_SUM: begin
                if (!r_found || score > r_best) begin
                    n_found  = 1'b1;
                    n_best   = score;
                    n_best_i = cnt_ext[3:0];
                end
                n_cnt = r_cnt + CW'(1);
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= RESET_ACTIVE;
            r_proto  <= '0;
            r_secure <= '0;
            r_base   <= RESET_BASE;
            r_minq   <= RESET_MINQ;
            r_vld    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_ACTIVE: r_active <= i_cfg.data[4:0];
                    CFG_PROTO:  r_proto  <= i_cfg.data;
                    CFG_SECURE: r_secure <= i_cfg.data[15:0];
                    CFG_BASE:   r_base   <= i_cfg.data[15:0];
                    CFG_MINQ:   r_minq   <= i_cfg.data[7:0];
                    default:    r_minq   <= r_minq;
                endcase
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (r_state == S_DONE && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld   <= r_vld[ram_raddr];
        r_mode     <= n_mode;
        r_idx      <= n_idx;
        r_ok       <= n_ok;
        r_time     <= n_time;
        r_rec      <= n_rec;
        r_cnt      <= n_cnt;
        r_speed    <= n_speed;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_found    <= n_found;
        r_best     <= n_best;
        r_best_i   <= n_best_i;
        r_x        <= n_x;
        r_rem5     <= n_rem5;
        r_step     <= n_step;
        r_res_rate <= n_res_rate;
        r_res_use  <= n_res_use;
        if (r_state == S_DONE && (!r_ov || o_out.ready)) begin
            if (!r_mode) begin
                r_o_chosen <= r_found ? r_best_i : 4'd0;
                r_o_none   <= !r_found;
                r_o_best   <= r_found ? r_best : 17'd0;
                r_o_rate   <= '0;
                r_o_use    <= 1'b0;
            end else begin
                r_o_chosen <= '0;
                r_o_none   <= 1'b0;
                r_o_best   <= '0;
                r_o_rate   <= r_res_rate;
                r_o_use    <= r_res_use;
            end
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.chosen_index    = r_o_chosen;
    assign o_out.none_available  = r_o_none;
    assign o_out.top_score       = r_o_best;
    assign o_out.rate_after      = r_o_rate;
    assign o_out.still_available = r_o_use;
endmodule

// ===== sv/wshs_chk.sv =====
// port checker for the weighted server health selector and its bind
module wshs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [3:0]  i_chosen,
    input logic        i_none,
    input logic [16:0] i_best,
    input logic [16:0] i_rate,
    input logic        i_use
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_best) && $stable(i_rate))
        else $error("result changed while stalled");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_none |-> i_chosen == 4'd0 && i_best == 17'd0 && i_rate == 17'd0)
        else $error("empty select carries data");

    a_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_best <= 17'd78643 && i_rate <= 17'd65536)
        else $error("score or rate out of range");

    a_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_rate != 17'd0 || i_use) |-> !i_none && i_best == 17'd0)
        else $error("update result mixed with select fields");
endmodule

bind weighted_server_health_selector wshs_chk u_wshs_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_chosen(o_out.chosen_index),
    .i_none  (o_out.none_available),
    .i_best  (o_out.top_score),
    .i_rate  (o_out.rate_after),
    .i_use   (o_out.still_available)
);

// ===== test/weighted_server_health_selector_tb.sv =====
// testbench for the weighted server health selector: directed and random requests checked against a scoreboard
`timescale 1ns / 1ps

module weighted_server_health_selector_tb;
    import wshs_pkg::*;

    typedef struct {
        logic        mode;
        logic [3:0]  entry_index;
        logic        succeeded;
        logic [31:0] response_ms;
    } t_req;

    typedef struct {
        logic [3:0]  chosen_index;
        logic        none_available;
        logic [16:0] top_score;
        logic [16:0] rate_after;
        logic        still_available;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wshs_in_if  in_if();
    wshs_out_if out_if();
    wshs_cfg_if cfg_if();

    weighted_server_health_selector uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // health table copy
    logic [31:0] hl_total [16];
    logic [31:0] hl_ok    [16];
    logic [31:0] hl_avg   [16];
    logic [16:0] hl_rate  [16];
    logic        hl_usable[16];

    logic [4:0]  sh_active;
    logic [47:0] sh_proto;
    logic [15:0] sh_secure;
    logic [15:0] sh_base;
    logic [7:0]  sh_minq;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   mismatches = 0;
    bit   quiet = 0;
    int   stall_cycles = 0;
    int   p, k;
    t_req rq;

    initial begin
        in_if.valid = 1'b0;
        in_if.mode = 1'b0;
        in_if.entry_index = '0;
        in_if.succeeded = 1'b0;
        in_if.response_ms = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_ACTIVE;
        cfg_if.data = '0;
    end

    function automatic logic [16:0] entry_score(int i);
        logic [63:0] speed;
        logic [63:0] sum;
        t_proto code;
        if (hl_avg[i] == 0) begin
            speed = 64'd65536;
        end else begin
            speed = {16'd0, sh_base, 16'd0} / {32'd0, hl_avg[i]};
            if (speed > 64'd65536) speed = 64'd65536;
        end
        sum = ({47'd0, hl_rate[i]} * 64'd45875 + speed * 64'd19661) >> 16;
        code = t_proto'(sh_proto[3*i +: 3]);
        if (code == PROTO_QUIC) sum = sum + 64'd9830;
        else if (code == PROTO_HTTPS) sum = sum + 64'd6554;
        else if (code == PROTO_TLS) sum = sum + 64'd5243;
        if (sh_secure[i]) sum = sum + 64'd3277;
        return sum[16:0];
    endfunction

    task automatic predict_health(input t_req r);
        t_res e;
        int cnt;
        bit found;
        logic [16:0] best, s;
        int best_i;
        int x;
        e = '{default: '0};
        if (r.mode == 1'b0) begin
            cnt = (sh_active < 16) ? sh_active : 16;
            found = 0;
            best = '0;
            best_i = 0;
            for (int i = 0; i < cnt; i++) begin
                if (hl_usable[i]) begin
                    s = entry_score(i);
                    if (!found || s > best) begin
                        found = 1;
                        best = s;
                        best_i = i;
                    end
                end
            end
            if (found) begin
                e.chosen_index = best_i[3:0];
                e.top_score = best;
            end else begin
                e.none_available = 1'b1;
            end
        end else begin
            x = r.entry_index;
            if (hl_total[x] != 32'hFFFF_FFFF) hl_total[x] = hl_total[x] + 1;
            if (r.succeeded) begin
                if (hl_ok[x] != 32'hFFFF_FFFF) hl_ok[x] = hl_ok[x] + 1;
                if (hl_avg[x] == 0) hl_avg[x] = r.response_ms;
                else hl_avg[x] = 32'((({32'd0, hl_avg[x]} * 64'd4) + {32'd0, r.response_ms})
                                     / 64'd5);
            end
            hl_rate[x] = 17'(({32'd0, hl_ok[x]} << 16) / {32'd0, hl_total[x]});
            if (hl_total[x] >= {24'd0, sh_minq} && hl_rate[x] < 17'd32768)
                hl_usable[x] = 1'b0;
            e.rate_after = hl_rate[x];
            e.still_available = hl_usable[x];
        end
        expected_res.push_back(e);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                rq.mode = in_if.mode;
                rq.entry_index = in_if.entry_index;
                rq.succeeded = in_if.succeeded;
                rq.response_ms = in_if.response_ms;
                predict_health(rq);
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
                    rq = pending_reqs.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.mode <= rq.mode;
                    in_if.entry_index <= rq.entry_index;
                    in_if.succeeded <= rq.succeeded;
                    in_if.response_ms <= rq.response_ms;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= quiet || ($urandom_range(0, 99) >= 23);
            if (out_if.valid && out_if.ready) begin
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transaction");
                end else begin
                    e = expected_res.pop_front();
                    if (out_if.chosen_index !== e.chosen_index ||
                        out_if.none_available !== e.none_available ||
                        out_if.top_score !== e.top_score ||
                        out_if.rate_after !== e.rate_after ||
                        out_if.still_available !== e.still_available) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                     e.chosen_index, e.none_available, e.top_score,
                                     e.rate_after, e.still_available,
                                     out_if.chosen_index, out_if.none_available,
                                     out_if.top_score, out_if.rate_after,
                                     out_if.still_available);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= 50000) begin
            $display("weighted_server_health_selector_tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_ACTIVE: sh_active = value[4:0];
            CFG_PROTO:  sh_proto = value;
            CFG_SECURE: sh_secure = value[15:0];
            CFG_BASE:   sh_base = value[15:0];
            CFG_MINQ:   sh_minq = value[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || in_if.valid || expected_res.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_req(input logic m, input logic [3:0] ix, input logic ok,
                           input logic [31:0] ms);
        t_req r;
        r.mode = m;
        r.entry_index = ix;
        r.succeeded = ok;
        r.response_ms = ms;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] pick_time();
        int c;
        c = $urandom_range(0, 9);
        if (c == 0) return 32'd0;
        if (c == 1) return 32'hFFFF_FFFF;
        if (c <= 3) return $urandom;
        return $urandom_range(1, 12000);
    endfunction

    task automatic add_random(input int count);
        int ok_pct;
        ok_pct = $urandom_range(0, 1) ? 85 : 40;
        for (int j = 0; j < count; j++) begin
            if ($urandom_range(0, 99) < 65)
                add_req(1'b1, 4'($urandom_range(0, 15)), $urandom_range(0, 99) < ok_pct,
                        pick_time());
            else
                add_req(1'b0, 4'($urandom), 1'($urandom), $urandom);
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            hl_total[i] = '0;
            hl_ok[i] = '0;
            hl_avg[i] = '0;
            hl_rate[i] = '0;
            hl_usable[i] = 1'b1;
        end
        sh_active = RESET_ACTIVE;
        sh_proto = '0;
        sh_secure = '0;
        sh_base = RESET_BASE;
        sh_minq = RESET_MINQ;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, then all protocol codes and extreme times
        add_req(1'b0, 4'd0, 1'b0, 32'd0);
        add_req(1'b1, 4'd3, 1'b1, 32'd0);
        drain();
        write_reg(CFG_ACTIVE, 48'd16);
        write_reg(CFG_PROTO, 48'o76543210_76543210);
        write_reg(CFG_SECURE, 48'hA5A5);
        add_req(1'b0, 4'd0, 1'b0, 32'd0);
        add_req(1'b1, 4'd0, 1'b1, 32'hFFFF_FFFF);
        add_req(1'b1, 4'd0, 1'b1, 32'hFFFF_FFFF);
        add_req(1'b1, 4'd1, 1'b1, 32'd1);
        add_req(1'b1, 4'd15, 1'b0, 32'd100);
        add_req(1'b1, 4'd15, 1'b1, 32'd5000);
        add_req(1'b1, 4'd2, 1'b1, 32'd4999);
        add_req(1'b1, 4'd2, 1'b1, 32'd5001);
        add_req(1'b1, 4'd4, 1'b1, 32'd0);
        add_req(1'b0, 4'hF, 1'b1, 32'hFFFF_FFFF);
        for (k = 0; k < 10; k++) add_req(1'b1, 4'd5, 1'b0, 32'd7);
        add_req(1'b0, 4'd0, 1'b0, 32'd0);
        drain();
        write_reg(CFG_MINQ, 48'd0);
        add_req(1'b1, 4'd6, 1'b0, 32'd9);
        add_req(1'b0, 4'd0, 1'b0, 32'd0);
        drain();

        for (p = 0; p < 8; p++) begin
            quiet = (p == 2);
            case (p)
                0: begin
                    write_reg(CFG_ACTIVE, 48'd16); write_reg(CFG_BASE, 48'd5000);
                    write_reg(CFG_MINQ, 48'd10);
                end
                1: begin
                    write_reg(CFG_ACTIVE, 48'd31); write_reg(CFG_BASE, 48'd1);
                    write_reg(CFG_MINQ, 48'd1);
                end
                2: begin
                    write_reg(CFG_BASE, 48'd65535); write_reg(CFG_MINQ, 48'd255);
                end
                3: write_reg(CFG_ACTIVE, 48'd0);
                4: begin
                    write_reg(CFG_ACTIVE, 48'd16); write_reg(CFG_BASE, 48'd0);
                end
                default: begin
                    write_reg(CFG_ACTIVE, 48'($urandom_range(1, 16)));
                    write_reg(CFG_BASE, 48'($urandom_range(1, 65535)));
                    write_reg(CFG_MINQ, 48'($urandom_range(1, 255)));
                end
            endcase
            write_reg(CFG_PROTO, 48'({$urandom, $urandom}));
            write_reg(CFG_SECURE, 48'($urandom));
            add_random(130);
            drain();
        end
        quiet = 0;

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_res.size() == 0) begin
            $display("weighted_server_health_selector_tb: done, clean");
        end else begin
            $display("weighted_server_health_selector_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/wshs_pkg.sv
sv/wshs_if.sv
sv/wshs_ram.sv
sv/wshs_div.sv
sv/weighted_server_health_selector.sv
sv/wshs_chk.sv
test/weighted_server_health_selector_tb.sv
